// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define AST_CHK(lbl, prp, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prp) else $error(msg);
`define AST_ANY(lbl, prp, msg) \
  lbl: assert property (@(posedge clk) prp) else $error(msg);
`else
`define AST_CHK(lbl, prp, msg)
`define AST_ANY(lbl, prp, msg)
`endif
`endif

// ===== rtl/ustk_pkg.sv =====
// Types and codes for the unique stack with search.
`default_nettype none
package ustk_pkg;

  localparam logic [1:0] FN_PUSH = 2'd0;
  localparam logic [1:0] FN_POP  = 2'd1;
  localparam logic [1:0] FN_LOC  = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_DUP      = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] value;
  } in_beat_t;

  typedef struct packed {
    logic [2:0] status;
    logic [5:0] position;
    logic [5:0] popped;
    logic [5:0] count;
  } out_beat_t;

  // search token passed from cell to cell
  typedef struct packed {
    logic act;
    logic hit;
  } tok_t;

endpackage
`default_nettype wire

// ===== rtl/ustk_if.sv =====
// Valid/ready channel interfaces for input and result beats.
`default_nettype none
interface ustk_in_if;
  import ustk_pkg::*;
  logic     valid;
  logic     ready;
  in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ustk_out_if;
  import ustk_pkg::*;
  logic      valid;
  logic      ready;
  out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/ustk_cell.sv =====
// One stack slot: holds an entry and compares it against the passing search token.
`default_nettype none
module ustk_cell #(
  parameter int DEPTH = 32,
  parameter int INDEX = 0
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [$clog2(DEPTH+1)-1:0]   fill,
  input  wire logic [31:0]                  key,
  input  wire logic                         we,
  input  wire ustk_pkg::tok_t               tok_in,
  input  wire logic [$clog2(DEPTH)-1:0]     idx_in,
  output ustk_pkg::tok_t                    tok_out,
  output logic [$clog2(DEPTH)-1:0]          idx_out
);
  import ustk_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  localparam logic [CW-1:0] MY_POS = CW'(INDEX);
  localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

  logic [31:0]   entry_r;
  tok_t          tok_r;
  logic [IW-1:0] idx_r;
  logic          match;

  assign match = tok_in.act && !tok_in.hit && (MY_POS < fill) && (entry_r == key);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r.act <= tok_in.act;
      tok_r.hit <= tok_in.hit | match;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= match ? MY_IDX : idx_in;
    if (we && (fill == MY_POS)) begin
      entry_r <= key;
    end
  end

  assign tok_out = tok_r;
  assign idx_out = idx_r;

endmodule
`default_nettype wire

// ===== rtl/unique_stack_with_search.sv =====
// Top level: bounded duplicate-free stack searched by a token walking a row of cells.
//
//   channel  dir  beat fields                         handshake
//   in_if    in   func, value                         valid/ready
//   out_if   out  status, position, popped, count     valid/ready
//
// One beat at a time; the next beat is accepted only after the result of the last has
// been registered, with the search token stepping one cell per clock along the row.
// The result sits in an output register; a new beat is taken while it waits.
// A stalled result holds the controller in its done state until out_if.ready.
// Reset (rst_n low, synchronous) empties the stack; entry contents are not cleared.
`default_nettype none
`include "assert_macros.svh"
module unique_stack_with_search #(
  parameter int DEPTH = 32
) (
  input wire logic   clk,
  input wire logic   rst_n,
  ustk_in_if.sink    in_if,
  ustk_out_if.source out_if
);
  import ustk_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SRCH = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [1:0]    func_r, func_nxt;
  logic [31:0]   key_r, key_nxt;
  logic          start_r, start_nxt;
  logic          hit_r, hit_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_beat_t     out_data_r;

  logic          in_fire;
  logic          res_fire;
  logic          we;
  logic [CW-1:0] found_pos;
  logic [2:0]    res_status;
  logic [CW-1:0] res_pos;
  logic [CW-1:0] res_popped;
  logic [CW-1:0] res_fill;

  tok_t          tok_c [DEPTH+1];
  logic [IW-1:0] idx_c [DEPTH+1];

  assign tok_c[0] = '{act: start_r, hit: 1'b0};
  assign idx_c[0] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    ustk_cell #(.DEPTH(DEPTH), .INDEX(i)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .fill    (fill_r),
      .key     (key_r),
      .we      (we),
      .tok_in  (tok_c[i]),
      .idx_in  (idx_c[i]),
      .tok_out (tok_c[i+1]),
      .idx_out (idx_c[i+1])
    );
  end

  assign in_if.ready = (state_r == S_IDLE);
  assign in_fire     = in_if.valid && in_if.ready;
  assign res_fire    = (state_r == S_DONE) && (!out_valid_r || out_if.ready);

  always_comb begin
    state_nxt = state_r;
    func_nxt  = func_r;
    key_nxt   = key_r;
    start_nxt = 1'b0;
    hit_nxt   = hit_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          func_nxt  = in_if.data.func;
          key_nxt   = in_if.data.value;
          start_nxt = 1'b1;
          state_nxt = S_SRCH;
        end
      end
      S_SRCH: begin
        if (tok_c[DEPTH].act) begin
          hit_nxt   = tok_c[DEPTH].hit;
          idx_nxt   = idx_c[DEPTH];
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (res_fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign found_pos = CW'(idx_r) + CW'(1);

  always_comb begin
    res_status = ST_OK;
    res_pos    = '0;
    res_popped = '0;
    res_fill   = fill_r;
    we         = 1'b0;
    unique case (func_r)
      FN_PUSH: begin
        if (hit_r) begin
          res_status = ST_DUP;
          res_pos    = found_pos;
        end else if (fill_r == DEPTH_C) begin
          res_status = ST_FULL;
        end else begin
          we       = res_fire;
          res_fill = fill_r + CW'(1);
          res_pos  = res_fill;
        end
      end
      FN_POP, FN_LOC: begin
        if (fill_r == '0) begin
          res_status = ST_EMPTY;
        end else if (!hit_r) begin
          res_status = ST_NOTFOUND;
        end else begin
          res_pos = found_pos;
          if (func_r == FN_POP) begin
            res_popped = fill_r - CW'(idx_r);
            res_fill   = CW'(idx_r);
          end
        end
      end
      default: ;
    endcase
  end

  assign fill_nxt      = res_fire ? res_fill : fill_r;
  assign out_valid_nxt = res_fire ? 1'b1 : (out_if.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= 1'b0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      start_r     <= start_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r <= func_nxt;
    key_r  <= key_nxt;
    hit_r  <= hit_nxt;
    idx_r  <= idx_nxt;
    if (res_fire) begin
      out_data_r.status   <= res_status;
      out_data_r.position <= 6'(res_pos);
      out_data_r.popped   <= 6'(res_popped);
      out_data_r.count    <= 6'(res_fill);
    end
  end

  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_data_r;

  `AST_CHK(a_fill_bound, fill_r <= DEPTH_C, "fill above depth")
  `AST_CHK(a_tok_in_srch, tok_c[DEPTH].act |-> state_r == S_SRCH, "token left row outside search")
  `AST_CHK(a_fill_on_res, !$stable(fill_r) |-> $past(res_fire), "fill moved without a result")
  `AST_CHK(a_out_from_done, $rose(out_valid_r) |-> $past(state_r == S_DONE), "result without search")
  `AST_ANY(a_rst_idle, !rst_n |=> state_r == S_IDLE && !out_valid_r, "reset did not idle")

endmodule
`default_nettype wire

// ===== sim/ustk_checker.sv =====
// Scoreboard for the unique stack: predicts each result beat and compares it.
`timescale 1ns / 100ps
module ustk_checker (
  input  logic clk,
  input  logic rst_n,
  ustk_in_if   in_mon,
  ustk_out_if  out_mon,
  output int   fail_count,
  output int   pending
);
  import ustk_pkg::*;

  localparam int DEPTH = 32;

  logic [31:0] stack_mem [DEPTH];
  int          stack_fill;
  out_beat_t   expected_results [$];

  initial begin
    fail_count = 0;
    pending    = 0;
    stack_fill = 0;
  end

  function automatic out_beat_t predict_response(in_beat_t b);
    out_beat_t r;
    int        hit;
    r        = '0;
    r.status = ST_OK;
    hit      = -1;
    for (int i = 0; i < stack_fill; i++) begin
      if (hit < 0 && stack_mem[i] == b.value) hit = i;
    end
    case (b.func)
      FN_PUSH: begin
        if (hit >= 0) begin
          r.status   = ST_DUP;
          r.position = 6'(hit + 1);
        end else if (stack_fill >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          stack_mem[stack_fill] = b.value;
          stack_fill++;
          r.position = 6'(stack_fill);
        end
      end
      FN_POP, FN_LOC: begin
        if (stack_fill == 0) begin
          r.status = ST_EMPTY;
        end else if (hit < 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          r.position = 6'(hit + 1);
          if (b.func == FN_POP) begin
            r.popped   = 6'(stack_fill - hit);
            stack_fill = hit;
          end
        end
      end
      default: ;
    endcase
    r.count = 6'(stack_fill);
    return r;
  endfunction

  always @(posedge clk) begin
    out_beat_t want;
    out_beat_t got;
    if (!rst_n) begin
      stack_fill = 0;
      expected_results.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got = out_mon.data;
        if (expected_results.size() == 0) begin
          $error("unexpected result beat: status %0d count %0d", got.status, got.count);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_count++;
          end
          if (got.position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, got.position);
            fail_count++;
          end
          if (got.popped !== want.popped) begin
            $error("popped: expected %0d, got %0d", want.popped, got.popped);
            fail_count++;
          end
          if (got.count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, got.count);
            fail_count++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) expected_results.push_back(predict_response(in_mon.data));
    end
    pending <= expected_results.size();
  end
endmodule

// ===== sim/testbench.sv =====
// Top of the unique stack testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module testbench;
  import ustk_pkg::*;

  localparam logic [1:0] FN_SPARE = 2'd3;
  localparam int POOL_SIZE = 40;
  localparam int RANDOM_ITEMS = 500;

  logic clk;
  logic rst_n;
  logic calm;
  int   fail_count;
  int   pending;
  int   ready_hold;
  logic [31:0] val_pool [POOL_SIZE];

  ustk_in_if  in_ch ();
  ustk_out_if out_ch ();

  unique_stack_with_search #(.DEPTH(32)) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch),
    .out_if(out_ch)
  );

  ustk_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    calm         = 1'b0;
    ready_hold   = 0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
  end

  always #10 clk = ~clk;

  // result-side backpressure in bursts
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      out_ch.ready <= 1'b0;
      ready_hold--;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      out_ch.ready <= 1'b0;
      ready_hold = $urandom_range(0, 10);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic send_beat(input logic [1:0] fn, input logic [31:0] v);
    in_beat_t b;
    b.func  = fn;
    b.value = v;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= b;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    if ($urandom_range(0, 99) < 85) return val_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  // 0: filling, 1: mixed, 2: draining
  function automatic logic [1:0] pick_func(int mode);
    int r;
    r = $urandom_range(0, 99);
    case (mode)
      0: begin
        if (r < 80) return FN_PUSH;
        if (r < 88) return FN_LOC;
        if (r < 96) return FN_POP;
      end
      1: begin
        if (r < 45) return FN_PUSH;
        if (r < 70) return FN_LOC;
        if (r < 95) return FN_POP;
      end
      default: begin
        if (r < 20) return FN_PUSH;
        if (r < 50) return FN_LOC;
        if (r < 97) return FN_POP;
      end
    endcase
    return FN_SPARE;
  endfunction

  initial begin : stimulus
    int sent;
    int mode;
    int len;
    val_pool[0] = 32'h8000_0000;
    val_pool[1] = 32'h7fff_ffff;
    val_pool[2] = 32'h0000_0000;
    val_pool[3] = 32'hffff_ffff;
    val_pool[4] = 32'h0000_0001;
    for (int i = 5; i < POOL_SIZE; i++) val_pool[i] = $urandom;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty cases, spare code, extremes, duplicate, hits and misses
    send_beat(FN_LOC,   32'd5);
    send_beat(FN_POP,   32'd5);
    send_beat(FN_SPARE, 32'd5);
    send_beat(FN_PUSH,  32'h8000_0000);
    send_beat(FN_PUSH,  32'h7fff_ffff);
    send_beat(FN_PUSH,  32'h0000_0000);
    send_beat(FN_PUSH,  32'hffff_ffff);
    send_beat(FN_PUSH,  32'h5555_5555);
    send_beat(FN_PUSH,  32'haaaa_aaaa);
    send_beat(FN_PUSH,  32'h7fff_ffff);
    send_beat(FN_LOC,   32'h8000_0000);
    send_beat(FN_LOC,   32'hffff_ffff);
    send_beat(FN_LOC,   32'd12345);
    send_beat(FN_POP,   32'd12345);
    send_beat(FN_SPARE, 32'hffff_ffff);
    send_beat(FN_POP,   32'haaaa_aaaa);
    send_beat(FN_POP,   32'h0000_0000);
    send_beat(FN_LOC,   32'h7fff_ffff);
    send_beat(FN_POP,   32'h8000_0000);
    send_beat(FN_LOC,   32'h8000_0000);

    drain_results();

    // fill well past full, with duplicates along the way
    sent = 0;
    for (int i = 0; i < 60; i++) begin
      send_beat(FN_PUSH, val_pool[$urandom_range(0, POOL_SIZE - 1)]);
      sent++;
    end
    send_beat(FN_PUSH, $urandom);
    sent++;

    while (sent < RANDOM_ITEMS) begin
      mode = $urandom_range(0, 2);
      len  = $urandom_range(15, 60);
      for (int i = 0; i < len && sent < RANDOM_ITEMS; i++) begin
        calm = (sent >= RANDOM_ITEMS - 60);
        send_beat(pick_func(mode), pick_value());
        sent++;
      end
    end

    drain_results();
    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #5ms;
    $display("testbench NOT OK");
    $finish;
  end
endmodule
